// ===== src/sorted_key_value_table_unit_assert.svh =====
// Assertion macros used by the table unit's top-level RTL file.
// SKVT_ASSERT checks a property that is disabled while reset is asserted.
// SKVT_ASSERT_ALWAYS checks a property at every clock edge, reset included.
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SKVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define SKVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SKVT_ASSERT(lbl, clk, rstn, prop, msg)

`define SKVT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/skvt_pkg.sv =====
package skvt_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned OutCntW  = 7;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [ValW-1:0]        val_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } state_e;

  // Commit controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins;  // insert a new key, shifting larger entries up
    logic upd;  // replace the value of the matching entry
  } cell_ctrl_t;

endpackage

// ===== src/skvt_in_if.sv =====
interface skvt_in_if
  import skvt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  key_t            key;
  val_t            value_in;

  modport source (output valid, output opcode, output key, output value_in, input ready);
  modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

// ===== src/skvt_out_if.sv =====
interface skvt_out_if
  import skvt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  val_t               value_out;
  logic               status;
  logic [OutCntW-1:0] entry_count;

  modport source (output valid, output found, output value_out, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input value_out, input status,
                  input entry_count, output ready);
endinterface

// ===== src/skvt_cell.sv =====
module skvt_cell
  import skvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       valid_i,     // this slot holds an entry
  input  logic       cmp_en_i,    // a transaction is being accepted
  input  key_t       cmp_key_i,
  input  key_t       new_key_i,
  input  val_t       new_val_i,
  input  cell_ctrl_t ctrl_i,
  input  key_t       left_key_i,
  input  val_t       left_val_i,
  input  logic       left_lt_i,
  output key_t       key_o,
  output val_t       val_o,
  output logic       lt_o,
  output logic       eq_o
);

  key_t key_q, key_d;
  val_t val_q, val_d;
  logic lt_q, lt_d;
  logic eq_q, eq_d;

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    key_d = key_q;
    val_d = val_q;
    if (cmp_en_i) begin
      lt_d = valid_i && (key_q < cmp_key_i);
      eq_d = valid_i && (key_q == cmp_key_i);
    end
    // Cells at or above the insertion slot move up by one; the slot itself
    // is the first cell whose left neighbor still holds a smaller key.
    if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d = new_key_i;
        val_d = new_val_i;
      end else begin
        key_d = left_key_i;
        val_d = left_val_i;
      end
    end
    if (ctrl_i.upd && eq_q) begin
      val_d = new_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    lt_q  <= lt_d;
    eq_q  <= eq_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ===== src/sorted_key_value_table_unit.sv =====
// Sorted key/value table: up to Capacity pairs of a signed 32-bit key and a
// 32-bit value, kept in ascending key order in a row of cells.
// Input channel in_i carries opcode (insert/replace, lookup, clear), key and
// value_in. Output channel out_o returns exactly one transaction per input:
// found, value_out, status (1 when an insert of a new key meets a full
// table) and entry_count after the operation.
// Timing: on acceptance every cell compares its key with the request key.
// In the next cycle the commit step shifts or updates the cells and loads
// the output register, so the result is valid once the registered compare
// flags and then the output register are loaded. No new request is taken
// until the commit is done: one request at a time is in flight over the
// compare stage followed by the shift stage of the cell row.
// A stalled output register holds its result; the next request is taken
// only once that result is consumed.
// Reset empties the table (entry count zero) and drops any pending result;
// cell contents are not cleared, since only slots below the count are used.
`include "sorted_key_value_table_unit_assert.svh"

module sorted_key_value_table_unit
  import skvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  skvt_in_if.sink    in_i,
  skvt_out_if.source out_o
);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;

  opcode_e cmd_op_q;
  key_t    cmd_key_q;
  val_t    cmd_val_q;

  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  val_t               vout_q, vout_d;
  logic               status_q, status_d;
  logic [OutCntW-1:0] ecnt_q, ecnt_d;

  logic       accept;
  logic       commit;
  logic       full;
  logic       hit;
  val_t       hit_val;
  cell_ctrl_t ctrl;

  key_t                key_a [Capacity];
  val_t                val_a [Capacity];
  logic [Capacity-1:0] lt_vec;
  logic [Capacity-1:0] eq_vec;
  logic [Capacity-1:0] vld_vec;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == ST_COMMIT);
  assign full       = (count_q == CntW'(Capacity));

  // Row of cells.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    key_t left_key;
    val_t left_val;
    logic left_lt;

    if (i == 0) begin : g_head
      assign left_key = cmd_key_q;
      assign left_val = cmd_val_q;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_key = key_a[i-1];
      assign left_val = val_a[i-1];
      assign left_lt  = lt_vec[i-1];
    end

    assign vld_vec[i] = (CntW'(i) < count_q);

    skvt_cell u_cell (
      .clk_i      (clk_i),
      .valid_i    (vld_vec[i]),
      .cmp_en_i   (accept),
      .cmp_key_i  (in_i.key),
      .new_key_i  (cmd_key_q),
      .new_val_i  (cmd_val_q),
      .ctrl_i     (ctrl),
      .left_key_i (left_key),
      .left_val_i (left_val),
      .left_lt_i  (left_lt),
      .key_o      (key_a[i]),
      .val_o      (val_a[i]),
      .lt_o       (lt_vec[i]),
      .eq_o       (eq_vec[i])
    );
  end

  // At most one cell matches, so the hit value is a plain AND-OR.
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < Capacity; i++) begin
      hit_val = hit_val | (eq_vec[i] ? val_a[i] : '0);
    end
  end
  assign hit = |eq_vec;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commit decisions and result.
  always_comb begin
    ctrl        = '0;
    count_d     = count_q;
    found_d     = found_q;
    vout_d      = vout_q;
    status_d    = status_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (commit) begin
      found_d  = 1'b0;
      vout_d   = '0;
      status_d = 1'b0;
      unique case (cmd_op_q)
        OP_INSERT: begin
          found_d = hit;
          if (hit) begin
            ctrl.upd = 1'b1;
          end else if (full) begin
            status_d = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + cnt_t'(1);
          end
        end
        OP_LOOKUP: begin
          found_d = hit;
          vout_d  = hit_val;
        end
        OP_CLEAR: count_d = '0;
        OP_NOP:   ;
        default:  ;
      endcase
      ecnt_d      = OutCntW'(count_d);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_op_q  <= opcode_e'(in_i.opcode);
      cmd_key_q <= in_i.key;
      cmd_val_q <= in_i.value_in;
    end
    found_q  <= found_d;
    vout_q   <= vout_d;
    status_q <= status_d;
    ecnt_q   <= ecnt_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = found_q;
  assign out_o.value_out   = vout_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = ecnt_q;

  `SKVT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Capacity), "entry count above capacity")
  `SKVT_ASSERT(a_accept_commit, clk_i, rst_ni, accept |=> commit, "accepted request did not commit")
  `SKVT_ASSERT(a_lt_prefix, clk_i, rst_ni, commit |-> ((lt_vec & (lt_vec + 1'b1)) == '0), "smaller-key cells are not a prefix of the row")
  `SKVT_ASSERT(a_single_hit, clk_i, rst_ni, commit |-> $onehot0(eq_vec), "more than one cell matched the key")
  `SKVT_ASSERT(a_refuse_full, clk_i, rst_ni, commit && status_d |-> full, "insert refused while table not full")

endmodule

// ===== bench/sorted_key_value_table_unit_test.sv =====
`timescale 1ns / 1ps

module sorted_key_value_table_unit_test
  import skvt_pkg::*;
();

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 440;
  localparam int unsigned HoldOffLen  = 300;
  localparam int unsigned DrainCycles = 10;

  localparam key_t KeyMin = key_t'(32'h8000_0000);
  localparam key_t KeyMax = key_t'(32'h7fff_ffff);

  typedef struct {
    logic               found;
    val_t               value_out;
    logic               status;
    logic [OutCntW-1:0] entry_count;
  } table_result_t;

  // Mirror of the table contents plus the queue of answers still owed by the block.
  class table_scoreboard;
    key_t          keys [Capacity];
    val_t          vals [Capacity];
    int            used;
    int            peak_used;
    int            errors;
    int            n_checked;
    int            n_hits;
    int            n_refused;
    int            n_clears;
    table_result_t pending_results[$];

    function void apply_request(opcode_e op, key_t k, val_t v);
      table_result_t exp_res;
      int            slot;
      bit            hit;
      slot = 0;
      while (slot < used && keys[slot] < k) slot++;
      hit = (slot < used) && (keys[slot] == k);
      exp_res.found     = 1'b0;
      exp_res.value_out = '0;
      exp_res.status    = 1'b0;
      case (op)
        OP_INSERT: begin
          exp_res.found = hit;
          if (hit) begin
            vals[slot] = v;
          end else if (used >= Capacity) begin
            exp_res.status = 1'b1;
            n_refused++;
          end else begin
            for (int i = used; i > slot; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[slot] = k;
            vals[slot] = v;
            used++;
          end
        end
        OP_LOOKUP: begin
          exp_res.found = hit;
          if (hit) exp_res.value_out = vals[slot];
        end
        OP_CLEAR: begin
          used = 0;
          n_clears++;
        end
        default: begin
        end
      endcase
      if (hit) n_hits++;
      if (used > peak_used) peak_used = used;
      exp_res.entry_count = OutCntW'(used);
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(logic fnd, val_t vout, logic st, logic [OutCntW-1:0] cnt);
      table_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: found=%0b value_out=%h status=%0b count=%0d",
               fnd, vout, st, cnt);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      n_checked++;
      if (fnd !== exp_res.found) begin
        $error("found: expected %0b, got %0b", exp_res.found, fnd);
        errors++;
      end
      if (vout !== exp_res.value_out) begin
        $error("value_out: expected %h, got %h", exp_res.value_out, vout);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0b, got %0b", exp_res.status, st);
        errors++;
      end
      if (cnt !== exp_res.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_res.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  skvt_in_if  in_if ();
  skvt_out_if out_if ();

  sorted_key_value_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  table_scoreboard table_sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_left;
  int sent_count;
  int cycle_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_if.ready = 1'b0;
      holdoff_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      table_sb.check_result(out_if.found, out_if.value_out, out_if.status, out_if.entry_count);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(input opcode_e op, input key_t k, input val_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.opcode   = op;
    in_if.key      = k;
    in_if.value_in = v;
    do @(posedge clk_i); while (!in_if.ready);
    table_sb.apply_request(op, k, v);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (table_sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Mostly keys near the current contents so that hits and neighbors are common.
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && table_sb.used > 0)
      return table_sb.keys[$urandom_range(0, table_sb.used - 1)];
    if (r < 55 && table_sb.used > 0)
      return table_sb.keys[$urandom_range(0, table_sb.used - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return KeyMin;
        1:       return KeyMax;
        2:       return key_t'(0);
        default: return key_t'(-1);
      endcase
    end
    if (r < 80) return key_t'($signed($urandom_range(0, 255)) - 128);
    return key_t'($urandom);
  endfunction

  task automatic fill_table();
    if ($urandom_range(0, 1)) send_request(OP_CLEAR, key_t'($urandom), $urandom);
    while (table_sb.used < Capacity) send_request(OP_INSERT, pick_key(), $urandom);
    // Full table: new keys are refused, present keys are still replaced.
    repeat ($urandom_range(3, 8)) send_request(OP_INSERT, pick_key(), $urandom);
    repeat ($urandom_range(2, 6)) send_request(OP_LOOKUP, pick_key(), $urandom);
  endtask

  task automatic mixed_traffic();
    int r;
    repeat (20) begin
      r = $urandom_range(0, 99);
      if (r < 45)      send_request(OP_INSERT, pick_key(), $urandom);
      else if (r < 88) send_request(OP_LOOKUP, pick_key(), $urandom);
      else if (r < 95) send_request(OP_NOP, pick_key(), $urandom);
      else             send_request(OP_CLEAR, pick_key(), $urandom);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold_off);
    int stop_at;
    int r;
    stop_at        = sent_count + PhaseItems;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) holdoff_left = HoldOffLen;
    while (sent_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15)      fill_table();
      else if (r < 25) send_request(OP_CLEAR, key_t'($urandom), $urandom);
      else             mixed_traffic();
    end
    wait_drained();
  endtask

  task automatic directed_checks();
    send_request(OP_LOOKUP, key_t'(0), 32'h0);
    send_request(OP_INSERT, KeyMax, 32'h1234_5678);
    send_request(OP_INSERT, KeyMin, 32'hffff_ffff);
    send_request(OP_INSERT, key_t'(0), 32'h0000_0001);
    send_request(OP_INSERT, key_t'(-1), 32'h8000_0000);
    send_request(OP_INSERT, key_t'(1), 32'hffff_ffff);
    send_request(OP_LOOKUP, KeyMin, 32'h0);
    send_request(OP_LOOKUP, KeyMax, 32'h0);
    send_request(OP_LOOKUP, key_t'(2), 32'h0);
    send_request(OP_INSERT, KeyMax, 32'h0);
    send_request(OP_LOOKUP, KeyMax, 32'hffff_ffff);
    send_request(OP_NOP, key_t'(-1), 32'hffff_ffff);
    send_request(OP_CLEAR, KeyMin, 32'h0);
    send_request(OP_LOOKUP, key_t'(-1), 32'h0);
    send_request(OP_INSERT, key_t'(32'h5555_5555), 32'haaaa_aaaa);
    send_request(OP_INSERT, key_t'(32'haaaa_aaaa), 32'h5555_5555);
    send_request(OP_LOOKUP, key_t'(32'h5555_5555), 32'h0);
    send_request(OP_LOOKUP, key_t'(32'haaaa_aaaa), 32'h0);
    send_request(OP_INSERT, key_t'(32'h5555_5555), 32'h0);
    send_request(OP_LOOKUP, key_t'(32'h5555_5554), 32'h0);
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.opcode    = OP_NOP;
    in_if.key       = '0;
    in_if.value_in  = '0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    holdoff_left    = 0;
    sent_count      = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_checks();
    run_phase(0, 0, 1'b0);
    run_phase(71, 0, 1'b0);
    run_phase(0, 71, 1'b1);
    run_phase(34, 34, 1'b0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (table_sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", table_sb.pending_results.size());
      table_sb.errors += table_sb.pending_results.size();
    end

    $display("Checked %0d transactions: %0d key hits, %0d inserts refused on a full table,",
             table_sb.n_checked, table_sb.n_hits, table_sb.n_refused);
    $display("%0d clears, peak occupancy %0d, under four idle/stall mixes and a long hold-off.",
             table_sb.n_clears, table_sb.peak_used);
    if (table_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
